/* src/ncts_pkg.sv */
// Shared constants, types and codes for the nearest centroid triangle search.
`default_nettype none
package ncts_pkg;

  localparam int unsigned MaxTri   = 1024;
  localparam int unsigned IdxW     = $clog2(MaxTri);
  localparam int unsigned CntW     = $clog2(MaxTri + 1);
  localparam int unsigned IdxOutW  = 10;
  localparam int unsigned CoordW   = 24;
  localparam int unsigned SumW     = CoordW + 2;
  localparam int unsigned SqW      = 2 * SumW;
  localparam int unsigned DistW    = 53;
  localparam int unsigned SurfW    = 8;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned InDataW  = 224;
  localparam int unsigned OutDataW = 80;

  localparam logic [DistW-1:0] LimitReset = 53'd589824000000000;
  localparam logic [SurfW-1:0] MatCntReset = 8'd179;

  localparam logic [CfgIdxW-1:0] RegLimit  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMatCnt = 1'd1;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdQuery = 2'd1,
    CmdClear = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StDrain  = 5'b00100,
    StLookup = 5'b01000,
    StResult = 5'b10000
  } state_e;

  // one stored reference triangle
  typedef struct packed {
    logic [SurfW-1:0] surf;
    logic [SumW-1:0]  sz;
    logic [SumW-1:0]  sy;
    logic [SumW-1:0]  sx;
  } entry_t;

  // token passed from cell to cell; coord[0] is consumed by the next cell
  typedef struct packed {
    logic                         vld;
    logic                         last;
    logic [IdxW-1:0]              idx;
    logic [NumAxes-1:0][SumW-1:0] coord;
    logic [DistW-1:0]             dist_sq;
  } chain_t;

  typedef struct packed {
    logic [DistW-1:0]   dist_sq;
    logic               known;
    logic [SurfW-1:0]   surf;
    logic [IdxOutW-1:0] idx;
    logic               found;
  } result_t;

endpackage
`default_nettype wire

/* src/nearest_centroid_triangle_search_core.sv */
// Top level: command decode, store, distance cell chain and minimum tracking.
//
// Usage: requests enter on the s_axis group. tuser carries the command (load,
// query, clear); tdata carries the nine vertex coordinates and a surface id.
// Load and clear give no result; loads past the store capacity are dropped.
// A query gives exactly one result on m_axis. During a query the store is read
// one entry per cycle and each entry walks a chain of three cells (one per axis,
// three stages each) before the running minimum is updated; then the winning
// entry is read again for its surface id. An empty store skips the scan.
// One request is worked on at a time; s_axis_tready is high only when the core
// is waiting for a request. A finished result sits in an output register, so
// new requests are taken while it waits; a later query holds in its final step
// until the receiver has taken the earlier result.
// Reset empties the store (count to zero), restores both config registers and
// drops any pending result. Config writes go through cfg_we_i whenever idle.
`default_nettype none
module nearest_centroid_triangle_search_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ncts_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ncts_pkg::DistW-1:0]        cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, surface_id
  input  wire logic [ncts_pkg::InDataW-1:0]      s_axis_tdata,
  // command
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // match_found, match_index, match_surface, material_known, match_distance, pad
  output logic [ncts_pkg::OutDataW-1:0]          m_axis_tdata
);

  localparam int unsigned CW = ncts_pkg::CoordW;
  localparam int unsigned SW = ncts_pkg::SumW;

  ncts_pkg::state_e state_q, state_d;

  logic [ncts_pkg::DistW-1:0] lim_q;
  logic [ncts_pkg::SurfW-1:0] mat_q;
  logic [ncts_pkg::CntW-1:0]  cnt_q;
  logic [ncts_pkg::CntW-1:0]  ptr_q;
  logic                       rd_vld_q, rd_last_q;
  logic [ncts_pkg::IdxW-1:0]  rd_idx_q;
  logic [ncts_pkg::DistW-1:0] best_q;
  logic [ncts_pkg::IdxW-1:0]  best_idx_q;
  logic                       found_q;
  ncts_pkg::result_t          out_q;
  logic                       out_vld_q;

  logic                       in_acc, issue_last, q_ld, wr_en, rd_en, hit, out_free;
  ncts_pkg::cmd_e             cmd;
  logic [SW-1:0]              sum_x, sum_y, sum_z;
  logic [ncts_pkg::IdxW-1:0]  rd_addr;
  ncts_pkg::entry_t           wr_data, rd_data;
  ncts_pkg::chain_t           chain [ncts_pkg::NumAxes+1];
  logic [ncts_pkg::NumAxes-1:0][SW-1:0] q_vec;
  logic [ncts_pkg::IdxW+ncts_pkg::IdxOutW-1:0] idx_ext;

  function automatic logic [SW-1:0] sum3(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                         input logic [CW-1:0] c);
    return SW'($signed(a)) + SW'($signed(b)) + SW'($signed(c));
  endfunction

  assign cmd    = ncts_pkg::cmd_e'(s_axis_tuser);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ncts_pkg::StIdle);

  assign sum_x = sum3(s_axis_tdata[0*CW +: CW], s_axis_tdata[3*CW +: CW],
                      s_axis_tdata[6*CW +: CW]);
  assign sum_y = sum3(s_axis_tdata[1*CW +: CW], s_axis_tdata[4*CW +: CW],
                      s_axis_tdata[7*CW +: CW]);
  assign sum_z = sum3(s_axis_tdata[2*CW +: CW], s_axis_tdata[5*CW +: CW],
                      s_axis_tdata[8*CW +: CW]);

  assign wr_data.sx   = sum_x;
  assign wr_data.sy   = sum_y;
  assign wr_data.sz   = sum_z;
  assign wr_data.surf = s_axis_tdata[9*CW +: ncts_pkg::SurfW];
  assign wr_en = in_acc && (cmd == ncts_pkg::CmdLoad)
              && (cnt_q < ncts_pkg::CntW'(ncts_pkg::MaxTri));
  assign q_ld  = in_acc && (cmd == ncts_pkg::CmdQuery);

  assign issue_last = (ptr_q + ncts_pkg::CntW'(1)) == cnt_q;
  assign rd_en   = (state_q == ncts_pkg::StScan) || (state_q == ncts_pkg::StLookup);
  assign rd_addr = (state_q == ncts_pkg::StLookup) ? best_idx_q : ptr_q[ncts_pkg::IdxW-1:0];

  ncts_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[ncts_pkg::IdxW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    chain[0].vld      = rd_vld_q;
    chain[0].last     = rd_last_q;
    chain[0].idx      = rd_idx_q;
    chain[0].coord[0] = rd_data.sx;
    chain[0].coord[1] = rd_data.sy;
    chain[0].coord[2] = rd_data.sz;
    chain[0].dist_sq  = '0;
  end

  assign q_vec[0] = sum_x;
  assign q_vec[1] = sum_y;
  assign q_vec[2] = sum_z;

  for (genvar g = 0; g < ncts_pkg::NumAxes; g++) begin : g_cell
    ncts_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .q_ld_i  (q_ld),
      .q_i     (q_vec[g]),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  assign hit      = chain[ncts_pkg::NumAxes].vld
                 && (chain[ncts_pkg::NumAxes].dist_sq < best_q);
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ncts_pkg::StIdle: begin
        if (q_ld) begin
          state_d = (cnt_q == '0) ? ncts_pkg::StLookup : ncts_pkg::StScan;
        end
      end
      ncts_pkg::StScan: begin
        if (issue_last) begin
          state_d = ncts_pkg::StDrain;
        end
      end
      ncts_pkg::StDrain: begin
        if (chain[ncts_pkg::NumAxes].vld && chain[ncts_pkg::NumAxes].last) begin
          state_d = ncts_pkg::StLookup;
        end
      end
      ncts_pkg::StLookup: state_d = ncts_pkg::StResult;
      ncts_pkg::StResult: begin
        if (out_free) begin
          state_d = ncts_pkg::StIdle;
        end
      end
      default: state_d = ncts_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ncts_pkg::StIdle;
      lim_q     <= ncts_pkg::LimitReset;
      mat_q     <= ncts_pkg::MatCntReset;
      cnt_q     <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ncts_pkg::StScan);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ncts_pkg::RegLimit:  lim_q <= cfg_data_i;
          ncts_pkg::RegMatCnt: mat_q <= cfg_data_i[ncts_pkg::SurfW-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        cnt_q <= cnt_q + ncts_pkg::CntW'(1);
      end else if (in_acc && (cmd == ncts_pkg::CmdClear)) begin
        cnt_q <= '0;
      end
      if (q_ld) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (state_q == ncts_pkg::StScan) begin
          ptr_q <= ptr_q + ncts_pkg::CntW'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if ((state_q == ncts_pkg::StResult) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign idx_ext = {{ncts_pkg::IdxOutW{1'b0}}, best_idx_q};

  always_ff @(posedge clk_i) begin
    rd_last_q <= issue_last;
    rd_idx_q  <= ptr_q[ncts_pkg::IdxW-1:0];
    if (q_ld) begin
      best_q     <= lim_q;
      best_idx_q <= '0;
    end else if (hit) begin
      best_q     <= chain[ncts_pkg::NumAxes].dist_sq;
      best_idx_q <= chain[ncts_pkg::NumAxes].idx;
    end
    if ((state_q == ncts_pkg::StResult) && out_free) begin
      // rd_data holds the winning entry read in the lookup step
      out_q.found   <= found_q;
      out_q.idx     <= found_q ? idx_ext[ncts_pkg::IdxOutW-1:0] : '0;
      out_q.surf    <= found_q ? rd_data.surf : '0;
      out_q.known   <= found_q && (rd_data.surf < mat_q);
      out_q.dist_sq <= found_q ? best_q : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(ncts_pkg::OutDataW - $bits(ncts_pkg::result_t))'(0), out_q};

  a_chain_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[ncts_pkg::NumAxes].vld |->
      (state_q == ncts_pkg::StScan) || (state_q == ncts_pkg::StDrain))
    else $error("cell chain output outside a scan");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ncts_pkg::CntW'(ncts_pkg::MaxTri))
    else $error("store count past capacity");

  a_match_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.found) |-> (out_q.dist_sq < lim_q))
    else $error("reported match not below limit");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.found) |->
      (out_q.idx == '0) && (out_q.dist_sq == '0) && !out_q.known)
    else $error("no-match result carries nonzero fields");

endmodule
`default_nettype wire

/* src/ncts_store.sv */
// Reference triangle store: one write port, one registered read port.
`default_nettype none
module ncts_store (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [ncts_pkg::IdxW-1:0] wr_addr_i,
  input  wire ncts_pkg::entry_t          wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [ncts_pkg::IdxW-1:0] rd_addr_i,
  output ncts_pkg::entry_t               rd_data_o
);

  ncts_pkg::entry_t mem [ncts_pkg::MaxTri];
  ncts_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

/* src/ncts_cell.sv */
// Distance cell: adds the squared difference of one axis to the passing token.
`default_nettype none
module ncts_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_ld_i,
  input  wire logic [ncts_pkg::SumW-1:0] q_i,
  input  wire ncts_pkg::chain_t          chain_i,
  output ncts_pkg::chain_t               chain_o
);

  logic [ncts_pkg::SumW-1:0] q_q;
  logic signed [ncts_pkg::SumW:0] diff;
  logic [ncts_pkg::SumW:0]   diff_abs;

  ncts_pkg::chain_t          s1_q, s1_d, s2_q, s3_q, s3_d;
  logic [ncts_pkg::SumW-1:0] mag_q;
  logic [ncts_pkg::SqW-1:0]  sq_q;

  always_ff @(posedge clk_i) begin
    if (q_ld_i) begin
      q_q <= q_i;
    end
  end

  always_comb begin
    diff = $signed({q_q[ncts_pkg::SumW-1], q_q})
         - $signed({chain_i.coord[0][ncts_pkg::SumW-1], chain_i.coord[0]});
    diff_abs = diff[ncts_pkg::SumW] ? ncts_pkg::SumW'(0) - diff : diff;
    s1_d = chain_i;
    // hand the remaining axes down one slot
    for (int k = 0; k < ncts_pkg::NumAxes - 1; k++) begin
      s1_d.coord[k] = chain_i.coord[k+1];
    end
    s1_d.coord[ncts_pkg::NumAxes-1] = '0;
  end

  always_comb begin
    s3_d = s2_q;
    s3_d.dist_sq = s2_q.dist_sq + ncts_pkg::DistW'(sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= diff_abs[ncts_pkg::SumW-1:0];
    sq_q  <= mag_q * mag_q;
  end

  assign chain_o = s3_q;

endmodule
`default_nettype wire
